FILE: rtl/core/v4alu_pkg.sv
// Shared command codes and command field width of the four-component vector unit.
package v4alu_pkg;

    localparam int CMD_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 4'd0,
        CMD_SUB   = 4'd1,
        CMD_SCALE = 4'd2,
        CMD_DIV   = 4'd3,
        CMD_DOT3  = 4'd4,
        CMD_DOT4  = 4'd5,
        CMD_LEN3  = 4'd6,
        CMD_LEN4  = 4'd7,
        CMD_NORM3 = 4'd8,
        CMD_NORM4 = 4'd9,
        CMD_CROSS = 4'd10
    } cmd_t;

endpackage

FILE: rtl/core/v4alu_if.sv
// Request and result channel interfaces of the vector unit.
interface v4alu_in_if
    import v4alu_pkg::*;
#(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic signed [W-1:0] a_x;
    logic signed [W-1:0] a_y;
    logic signed [W-1:0] a_z;
    logic signed [W-1:0] a_w;
    logic signed [W-1:0] b_x;
    logic signed [W-1:0] b_y;
    logic signed [W-1:0] b_z;
    logic signed [W-1:0] b_w;
    logic signed [W-1:0] scalar_in;

    modport source (
        output valid, command, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in,
        input  ready
    );
    modport sink (
        input  valid, command, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in,
        output ready
    );
endinterface

interface v4alu_out_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] res_x;
    logic signed [W-1:0] res_y;
    logic signed [W-1:0] res_z;
    logic signed [W-1:0] res_w;
    logic signed [W-1:0] res_scalar;
    logic                divide_error;

    modport source (
        output valid, res_x, res_y, res_z, res_w, res_scalar, divide_error,
        input  ready
    );
    modport sink (
        input  valid, res_x, res_y, res_z, res_w, res_scalar, divide_error,
        output ready
    );
endinterface

FILE: rtl/core/vector4_fixed_point_alu.sv
// Pipelined four-component fixed-point vector ALU (top level).
//
// Usage: one request channel (in_ch) carries a command, vectors a and b and a
// scalar; one result channel (out_ch) returns the result vector, a scalar and
// the divide error flag. Both channels use valid/ready; a transaction happens
// on a clock edge with valid and ready high.
// Every command runs through the same pipeline: multiply, sum, round, one
// square-root bit per stage (WORD_WIDTH+1 stages), then one quotient bit per
// stage (WORD_WIDTH+FRAC_BITS stages), then the output register.
// Operands and results are signed fixed point, Q16.16 at the default widths.
// Throughput: one transaction per cycle while no waiting result is stalled, set
// by the fully unrolled root and divide chains.
// Reset clears all valid bits; the pipe is empty and ready after reset.
// When the receiver holds ready low with a result waiting, the whole pipe
// freezes and in_ch.ready drops; nothing is lost or repeated.
module vector4_fixed_point_alu
    import v4alu_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int WORD_WIDTH = 32
) (
    input logic         clk,
    input logic         rst_n,
    v4alu_in_if.sink    in_ch,
    v4alu_out_if.source out_ch
);

    localparam int W    = WORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2 * W;
    localparam int SW   = 2 * W + 2;
    localparam int RW   = W + 1;
    localparam int RMW  = RW + 3;
    localparam int NW   = W + F;
    localparam int DW   = W + 1;
    localparam int SQ_N = RW;
    localparam int DV_N = NW;

    localparam logic [W-1:0]  WMAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  WMIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic [NW:0]   HALF_Q = {{(NW+1-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
    localparam logic [SW-1:0] RND_C  = {{(SW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

    function automatic logic signed [PW-1:0] smul(input logic signed [W-1:0] x,
                                                  input logic signed [W-1:0] y);
        logic signed [PW-1:0] xe;
        logic signed [PW-1:0] ye;
        xe = x;
        ye = y;
        return xe * ye;
    endfunction

    function automatic logic signed [SW-1:0] pext(input logic signed [PW-1:0] p);
        logic signed [SW-1:0] e;
        e = p;
        return e;
    endfunction

    // Q(2F) -> Q(F): round half up, saturate to the word
    function automatic logic [W-1:0] rnd_sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        logic signed [SW-1:0] sh;
        t  = v + $signed(RND_C);
        sh = t >>> F;
        if (sh[SW-1:W-1] == {(SW-W+1){sh[SW-1]}})
            return sh[W-1:0];
        else
            return sh[SW-1] ? WMIN : WMAX;
    endfunction

    function automatic logic [W-1:0] add_sat(input logic [W-1:0] x, input logic [W-1:0] y,
                                             input logic sub);
        logic [W:0] s;
        if (sub)
            s = {x[W-1], x} - {y[W-1], y};
        else
            s = {x[W-1], x} + {y[W-1], y};
        if (s[W] == s[W-1])
            return s[W-1:0];
        else
            return s[W] ? WMIN : WMAX;
    endfunction

    function automatic logic [W-1:0] wmag(input logic [W-1:0] x);
        return x[W-1] ? (~x + 1'b1) : x;
    endfunction

    logic adv;
    logic out_vld_reg;

    assign adv         = !out_vld_reg || out_ch.ready;
    assign in_ch.ready = adv;

    // ------------------------------------------------------------------
    // Stage 1: operand select and products, add/sub
    // ------------------------------------------------------------------
    logic [3:0][W-1:0] ia;
    logic [3:0][W-1:0] ib;
    logic [3:0][W-1:0] x0, y0, x1, y1;

    assign ia = {in_ch.a_w, in_ch.a_z, in_ch.a_y, in_ch.a_x};
    assign ib = {in_ch.b_w, in_ch.b_z, in_ch.b_y, in_ch.b_x};

    always_comb
    begin
        x0 = ia;
        y0 = {4{in_ch.scalar_in}};
        x1 = '0;
        y1 = '0;
        unique case (in_ch.command)
            CMD_DOT3, CMD_DOT4:
            begin
                y0 = ib;
            end
            CMD_LEN3, CMD_LEN4, CMD_NORM3, CMD_NORM4:
            begin
                y0 = ia;
            end
            CMD_CROSS:
            begin
                x0 = {ia[3], ia[0], ia[2], ia[1]};
                y0 = {ib[3], ib[1], ib[0], ib[2]};
                x1 = {ia[3], ia[1], ia[0], ia[2]};
                y1 = {ib[3], ib[0], ib[2], ib[1]};
            end
            default:
            begin
                x0 = ia;
            end
        endcase
    end

    logic                 st1_vld_reg;
    logic [CMD_W-1:0]     st1_cmd_reg;
    logic [3:0][W-1:0]    st1_a_reg;
    logic [W-1:0]         st1_s_reg;
    logic [3:0][W-1:0]    st1_as_reg;
    logic signed [PW-1:0] st1_p0_reg [4];
    logic signed [PW-1:0] st1_p1_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st1_vld_reg <= 1'b0;
        else if (adv)
            st1_vld_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st1_cmd_reg <= in_ch.command;
            st1_a_reg   <= ia;
            st1_s_reg   <= in_ch.scalar_in;
            for (int i = 0; i < 4; i++)
            begin
                st1_p0_reg[i] <= smul(x0[i], y0[i]);
                st1_p1_reg[i] <= smul(x1[i], y1[i]);
                st1_as_reg[i] <= add_sat(ia[i], ib[i], in_ch.command == CMD_SUB);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sums and differences of products
    // ------------------------------------------------------------------
    logic                 st2_vld_reg;
    logic [CMD_W-1:0]     st2_cmd_reg;
    logic [3:0][W-1:0]    st2_a_reg;
    logic [W-1:0]         st2_s_reg;
    logic [3:0][W-1:0]    st2_as_reg;
    logic signed [SW-1:0] st2_lane_reg [4];
    logic signed [SW-1:0] st2_sum_reg;
    logic                 four;

    assign four = (st1_cmd_reg == CMD_DOT4) || (st1_cmd_reg == CMD_LEN4)
               || (st1_cmd_reg == CMD_NORM4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st2_vld_reg <= 1'b0;
        else if (adv)
            st2_vld_reg <= st1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st2_cmd_reg <= st1_cmd_reg;
            st2_a_reg   <= st1_a_reg;
            st2_s_reg   <= st1_s_reg;
            st2_as_reg  <= st1_as_reg;
            for (int i = 0; i < 4; i++)
                st2_lane_reg[i] <= pext(st1_p0_reg[i]) - pext(st1_p1_reg[i]);
            st2_sum_reg <= pext(st1_p0_reg[0]) + pext(st1_p0_reg[1]) + pext(st1_p0_reg[2])
                         + (four ? pext(st1_p0_reg[3]) : '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3 (root chain entry): round, saturate, early results
    // ------------------------------------------------------------------
    logic                 sq_vld_reg  [SQ_N+1];
    logic [CMD_W-1:0]     sq_cmd_reg  [SQ_N+1];
    logic [3:0][W-1:0]    sq_a_reg    [SQ_N+1];
    logic [W-1:0]         sq_s_reg    [SQ_N+1];
    logic [3:0][W-1:0]    sq_vec_reg  [SQ_N+1];
    logic [W-1:0]         sq_scal_reg [SQ_N+1];
    logic [RMW-1:0]       sq_rem_reg  [SQ_N+1];
    logic [RW-1:0]        sq_root_reg [SQ_N+1];
    logic [SW-1:0]        sq_rad_reg  [SQ_N+1];

    logic [3:0][W-1:0]    vec3_next;
    logic [W-1:0]         scal3_next;

    always_comb
    begin
        vec3_next  = '0;
        scal3_next = '0;
        unique case (st2_cmd_reg)
            CMD_ADD, CMD_SUB:
            begin
                vec3_next = st2_as_reg;
            end
            CMD_SCALE:
            begin
                for (int i = 0; i < 4; i++)
                    vec3_next[i] = rnd_sat(st2_lane_reg[i]);
            end
            CMD_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                    vec3_next[i] = rnd_sat(st2_lane_reg[i]);
                vec3_next[3] = st2_a_reg[3];
            end
            CMD_DOT3, CMD_DOT4:
            begin
                scal3_next = rnd_sat(st2_sum_reg);
            end
            default:
            begin
                scal3_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_vld_reg[0] <= 1'b0;
        else if (adv)
            sq_vld_reg[0] <= st2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_cmd_reg[0]  <= st2_cmd_reg;
            sq_a_reg[0]    <= st2_a_reg;
            sq_s_reg[0]    <= st2_s_reg;
            sq_vec_reg[0]  <= vec3_next;
            sq_scal_reg[0] <= scal3_next;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_rad_reg[0]  <= st2_sum_reg;  // sum of squares is never negative
        end
    end

    // one root bit per stage, two radicand bits in
    for (genvar k = 1; k <= SQ_N; k++)
    begin : g_sqrt
        logic [RMW-1:0] rem_sh;
        logic [RMW-1:0] trial;
        logic [RMW-1:0] rem_next;
        logic [RW-1:0]  root_next;

        always_comb
        begin
            rem_sh = {sq_rem_reg[k-1][RMW-3:0], sq_rad_reg[k-1][SW-1 -: 2]};
            trial  = {1'b0, sq_root_reg[k-1], 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {sq_root_reg[k-1][RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {sq_root_reg[k-1][RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[k] <= 1'b0;
            else if (adv)
                sq_vld_reg[k] <= sq_vld_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_cmd_reg[k]  <= sq_cmd_reg[k-1];
                sq_a_reg[k]    <= sq_a_reg[k-1];
                sq_s_reg[k]    <= sq_s_reg[k-1];
                sq_vec_reg[k]  <= sq_vec_reg[k-1];
                sq_scal_reg[k] <= sq_scal_reg[k-1];
                sq_rem_reg[k]  <= rem_next;
                sq_root_reg[k] <= root_next;
                sq_rad_reg[k]  <= {sq_rad_reg[k-1][SW-3:0], 2'b00};
            end
        end
    end

    // ------------------------------------------------------------------
    // Divide chain entry: round the root, pick divisor and numerators
    // ------------------------------------------------------------------
    logic                 dv_vld_reg  [DV_N+1];
    logic [CMD_W-1:0]     dv_cmd_reg  [DV_N+1];
    logic [3:0]           dv_an_reg   [DV_N+1];
    logic [3:0]           dv_az_reg   [DV_N+1];
    logic [3:0]           dv_neg_reg  [DV_N+1];
    logic [DW-1:0]        dv_d_reg    [DV_N+1];
    logic [3:0][W-1:0]    dv_vec_reg  [DV_N+1];
    logic [W-1:0]         dv_scal_reg [DV_N+1];
    logic [3:0][DW-1:0]   dv_rem_reg  [DV_N+1];
    logic [3:0][NW-1:0]   dv_nq_reg   [DV_N+1];

    logic [CMD_W-1:0]     e_cmd;
    logic [3:0][W-1:0]    e_a;
    logic                 e_div;
    logic                 e_len;
    logic                 len_up;
    logic [RW-1:0]        len;
    logic [W-1:0]         scal_e_next;
    logic [DW-1:0]        d_next;
    logic [3:0]           an_next;
    logic [3:0]           az_next;
    logic [3:0]           neg_next;
    logic [3:0][NW-1:0]   num_next;

    assign e_cmd = sq_cmd_reg[SQ_N];
    assign e_a   = sq_a_reg[SQ_N];
    assign e_div = e_cmd == CMD_DIV;
    assign e_len = (e_cmd == CMD_LEN3) || (e_cmd == CMD_LEN4)
                || (e_cmd == CMD_NORM3) || (e_cmd == CMD_NORM4);

    always_comb
    begin
        len_up = sq_rem_reg[SQ_N] > {3'b000, sq_root_reg[SQ_N]};
        len    = sq_root_reg[SQ_N] + {{(RW-1){1'b0}}, len_up};
        if (!e_len)
            scal_e_next = sq_scal_reg[SQ_N];
        else if (len[RW-1:W-1] != 2'b00)
            scal_e_next = WMAX;
        else
            scal_e_next = len[W-1:0];
        d_next = e_div ? {1'b0, wmag(sq_s_reg[SQ_N])} : len;
        for (int i = 0; i < 4; i++)
        begin
            an_next[i]  = e_a[i][W-1];
            az_next[i]  = e_a[i] == '0;
            neg_next[i] = e_a[i][W-1] ^ (e_div & sq_s_reg[SQ_N][W-1]);
            num_next[i] = {wmag(e_a[i]), {F{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld_reg[0] <= 1'b0;
        else if (adv)
            dv_vld_reg[0] <= sq_vld_reg[SQ_N];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_cmd_reg[0]  <= e_cmd;
            dv_an_reg[0]   <= an_next;
            dv_az_reg[0]   <= az_next;
            dv_neg_reg[0]  <= neg_next;
            dv_d_reg[0]    <= d_next;
            dv_vec_reg[0]  <= sq_vec_reg[SQ_N];
            dv_scal_reg[0] <= scal_e_next;
            dv_rem_reg[0]  <= '0;
            dv_nq_reg[0]   <= num_next;
        end
    end

    // restoring division, one quotient bit per stage on all four lanes;
    // the quotient shifts in where the numerator shifts out
    for (genvar j = 1; j <= DV_N; j++)
    begin : g_div
        logic [3:0][DW-1:0] rem_next;
        logic [3:0][NW-1:0] nq_next;
        logic [DW:0]        rs    [4];
        logic [DW:0]        diff  [4];
        logic [DW:0]        dext;

        always_comb
        begin
            dext = {1'b0, dv_d_reg[j-1]};
            for (int i = 0; i < 4; i++)
            begin
                rs[i]   = {dv_rem_reg[j-1][i], dv_nq_reg[j-1][i][NW-1]};
                diff[i] = rs[i] - dext;
                if (rs[i] >= dext)
                begin
                    rem_next[i] = diff[i][DW-1:0];
                    nq_next[i]  = {dv_nq_reg[j-1][i][NW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = rs[i][DW-1:0];
                    nq_next[i]  = {dv_nq_reg[j-1][i][NW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[j] <= 1'b0;
            else if (adv)
                dv_vld_reg[j] <= dv_vld_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_cmd_reg[j]  <= dv_cmd_reg[j-1];
                dv_an_reg[j]   <= dv_an_reg[j-1];
                dv_az_reg[j]   <= dv_az_reg[j-1];
                dv_neg_reg[j]  <= dv_neg_reg[j-1];
                dv_d_reg[j]    <= dv_d_reg[j-1];
                dv_vec_reg[j]  <= dv_vec_reg[j-1];
                dv_scal_reg[j] <= dv_scal_reg[j-1];
                dv_rem_reg[j]  <= rem_next;
                dv_nq_reg[j]   <= nq_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: quotient rounding, divide-by-zero, final select
    // ------------------------------------------------------------------
    logic [CMD_W-1:0]  f_cmd;
    logic              f_quot;
    logic              f_zero;
    logic [3:0][W-1:0] qv;
    logic [3:0][W-1:0] vec_out_next;
    logic [3:0]        q_up;
    logic [NW:0]       qr    [4];
    logic [3:0]        q_ovf;
    logic [W-1:0]      qneg  [4];

    logic [3:0][W-1:0] res_vec_reg;
    logic [W-1:0]      res_scal_reg;
    logic              res_err_reg;

    assign f_cmd  = dv_cmd_reg[DV_N];
    assign f_quot = (f_cmd == CMD_DIV) || (f_cmd == CMD_NORM3) || (f_cmd == CMD_NORM4);
    assign f_zero = dv_d_reg[DV_N] == '0;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            // round half away from zero: bump when twice the remainder reaches the divisor
            q_up[i]  = {dv_rem_reg[DV_N][i], 1'b0} >= {1'b0, dv_d_reg[DV_N]};
            qr[i]    = {1'b0, dv_nq_reg[DV_N][i]} + {{NW{1'b0}}, q_up[i]};
            q_ovf[i] = dv_neg_reg[DV_N][i] ? (qr[i] > HALF_Q) : (qr[i] >= HALF_Q);
            qneg[i]  = ~qr[i][W-1:0] + 1'b1;
            if (f_zero)
                qv[i] = dv_an_reg[DV_N][i] ? WMIN : (dv_az_reg[DV_N][i] ? '0 : WMAX);
            else if (q_ovf[i])
                qv[i] = dv_neg_reg[DV_N][i] ? WMIN : WMAX;
            else
                qv[i] = dv_neg_reg[DV_N][i] ? qneg[i] : qr[i][W-1:0];
        end
        vec_out_next = f_quot ? qv : dv_vec_reg[DV_N];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= dv_vld_reg[DV_N];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_vec_reg  <= vec_out_next;
            res_scal_reg <= dv_scal_reg[DV_N];
            res_err_reg  <= f_quot & f_zero;
        end
    end

    assign out_ch.valid        = out_vld_reg;
    assign out_ch.res_x        = res_vec_reg[0];
    assign out_ch.res_y        = res_vec_reg[1];
    assign out_ch.res_z        = res_vec_reg[2];
    assign out_ch.res_w        = res_vec_reg[3];
    assign out_ch.res_scalar   = res_scal_reg;
    assign out_ch.divide_error = res_err_reg;

endmodule
